>>> hw/rtl/bitmap_granule_allocator_assert.svh
// Assertion macros shared by the granule allocator RTL.
`ifndef BITMAP_GRANULE_ALLOCATOR_ASSERT_SVH
`define BITMAP_GRANULE_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBA_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GBA_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

>>> hw/rtl/gba_pkg.sv
// Shared constants and types for the granule allocator.
`timescale 1ns / 1ps
package gba_pkg;

  // Width of granule indexes, sums and scan pointers.
  localparam int LW = 16;
  // Width of a request's granule count.
  localparam int CNT_W = 14;
  // Width of the dividend of the remainder unit (granule address).
  localparam int XW = 31;
  // Width of the alignment in granules.
  localparam int DW = 10;
  // Largest region size in bytes.
  localparam int SIZE_CAP = 4096;

  // Request types.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [7:0] CFG_REGION_BASE = 8'd0;
  localparam logic [7:0] CFG_REGION_SIZE = 8'd1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_ALIGN    = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_TOO_SMALL    = 3'd3,
    ST_FREE_IGNORED = 3'd4
  } status_t;

endpackage

>>> hw/rtl/gba_ram.sv
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module gba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on request, read data registered every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/gba_mod.sv
// Bit-serial remainder unit: x mod d, one dividend bit per cycle.
`timescale 1ns / 1ps
module gba_mod (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [gba_pkg::XW-1:0] x,
  input  logic [gba_pkg::DW-1:0] d,
  output logic                  done,
  output logic [gba_pkg::DW-1:0] rem
);
  import gba_pkg::*;

  localparam int CNTW = $clog2(XW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [XW-1:0]   sh;
  logic [DW-1:0]   d_r;
  logic [DW:0]     trial;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem, sh[XW-1]};

  // Control: run through every dividend bit, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(XW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring remainder step.
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= x;
      d_r <= d;
      rem <= '0;
    end else if (busy) begin
      sh <= sh << 1;
      if (trial >= {1'b0, d_r}) begin
        rem <= DW'(trial - {1'b0, d_r});
      end else begin
        rem <= DW'(trial);
      end
    end
  end

endmodule

>>> hw/rtl/bitmap_granule_allocator.sv
// Top level of the bitmap granule allocator (next-fit, then first-fit).
// Allocate: an alignment remainder, then a scan of the granules of each candidate tried,
// then the granted granules are marked.
// Free: the granules are cleared, then the roving position walks back over free granules.
// One request is in work at a time; the bitmap RAM port is the limiting resource.
// Reset and each region register write clear all MAX_GRANULES map entries in one pass.
`timescale 1ns / 1ps
`include "bitmap_granule_allocator_assert.svh"
module bitmap_granule_allocator #(
  parameter int MAX_GRANULES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [15:0] request_bytes,
  input  logic [12:0] alignment,
  input  logic [31:0] block_address,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  status,
  output logic [31:0] granted_address
);
  import gba_pkg::*;

  localparam int AW = $clog2(MAX_GRANULES);
  localparam int CW = AW + 1;

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_DIV    = 12'b000000000100,
    S_CHK    = 12'b000000001000,
    S_SCAN   = 12'b000000010000,
    S_MARK   = 12'b000000100000,
    S_FCHK   = 12'b000001000000,
    S_BACKRD = 12'b000010000000,
    S_BACKCK = 12'b000100000000,
    S_DONE   = 12'b001000000000
  } state_t;

  state_t state;

  logic [31:0] region_base;
  logic [12:0] region_size;

  // Geometry, registered from the configuration.
  logic [29:0]   ds8;
  logic [CW-1:0] total;
  logic          too_small;

  logic [12:0] size_cap;
  logic [9:0]  map_bits;
  logic [6:0]  map_bytes;
  logic [32:0] ds_raw;
  logic [7:0]  overhead;
  logic [12:0] net;
  logic [9:0]  ng;

  // Request and scan state.
  logic [LW-1:0]    idx;
  logic [LW-1:0]    end_idx;
  logic [LW-1:0]    start;
  logic [CW-1:0]    rove;
  logic [CW-1:0]    rove_m1;
  logic [CW-1:0]    rove_eff;
  logic             pend;
  logic             phase_ff;
  logic             type_r;
  logic [CNT_W-1:0] count_r;
  logic [DW-1:0]    a8;
  logic [31:0]      addr_r;
  status_t          res_status;
  logic [31:0]      res_addr;

  // Remainder unit connection.
  logic          mod_go;
  logic [XW-1:0] mod_x;
  logic          mod_done;
  logic [DW-1:0] mod_rem;

  // Bitmap RAM connection.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic          ram_wdata;
  logic          ram_rdata;

  // Datapath helpers.
  logic [DW-1:0]    adj;
  logic [LW:0]      fit_sum;
  logic             fit_over;
  logic [XW-1:0]    gsum;
  logic [32:0]      ds_full;
  logic [32:0]      fdiff;
  logic             f_below;
  logic [30:0]      fsum;
  logic             f_over;
  logic [CNT_W-1:0] req_count;
  logic             bad_align;
  logic             cfg_hit;

  // Region geometry from the two configuration registers.
  always_comb begin
    size_cap  = (region_size > 13'(SIZE_CAP)) ? 13'(SIZE_CAP) : region_size;
    map_bits  = 10'((size_cap + 13'd7) >> 3);
    map_bytes = 7'((map_bits + 10'd7) >> 3);
    ds_raw    = {1'b0, region_base} + 33'(map_bytes) + 33'd7;
    overhead  = 8'({ds_raw[32:3], 3'b000} - {1'b0, region_base});
    net       = size_cap - 13'(overhead);
    ng        = 10'((net + 13'd7) >> 3);
  end

  always_ff @(posedge clk) begin
    ds8       <= ds_raw[32:3];
    too_small <= 13'(overhead) >= size_cap;
    if (LW'(ng) > LW'(MAX_GRANULES)) begin
      total <= CW'(MAX_GRANULES);
    end else begin
      total <= CW'(ng);
    end
  end

  // Request decode and address arithmetic.
  assign req_count = CNT_W'(({1'b0, request_bytes} + 17'd7) >> 3);
  assign bad_align = (alignment == 13'd0) || (alignment[2:0] != 3'd0);
  assign rove_eff  = (rove >= total) ? '0 : rove;
  assign rove_m1   = rove - 1'b1;
  assign adj       = (mod_rem == '0) ? '0 : (a8 - mod_rem);
  assign fit_sum   = {1'b0, start} + (LW + 1)'(count_r);
  assign fit_over  = fit_sum > (LW + 1)'(total);
  assign gsum      = XW'(ds8) + XW'(start);
  assign ds_full   = {ds8, 3'b000};
  assign fdiff     = {1'b0, addr_r} - ds_full;
  assign f_below   = {1'b0, addr_r} < ds_full;
  assign fsum      = {1'b0, fdiff[32:3]} + 31'(count_r);
  assign f_over    = fsum > 31'(total);
  assign cfg_hit   = (cfg_index == CFG_REGION_BASE) || (cfg_index == CFG_REGION_SIZE);

  // Handshakes.
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);
  assign req_ready = (state == S_IDLE) && !cfg_valid;

  // Bitmap RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx[AW-1:0];
    ram_wdata = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_MARK: begin
        ram_we    = (idx != end_idx);
        ram_wdata = (type_r == REQ_ALLOC);
      end
      S_BACKRD: begin
        ram_addr = rove_m1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  gba_ram #(
    .WIDTH(1),
    .DEPTH(MAX_GRANULES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  gba_mod u_mod (
    .clk (clk),
    .rst (rst),
    .start(mod_go),
    .x   (mod_x),
    .d   (a8),
    .done(mod_done),
    .rem (mod_rem)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      rove        <= '0;
      pend        <= 1'b0;
      mod_go      <= 1'b0;
      rsp_valid   <= 1'b0;
      region_base <= 32'd0;
      region_size <= 13'(SIZE_CAP);
    end else begin
      mod_go <= 1'b0;
      // A response taken while the next one is ready is replaced in S_DONE.
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          // A register write in this cycle restarts the pass below.
          if (!(cfg_valid && cfg_hit)) begin
            idx <= idx + 1'b1;
            if (idx[AW-1:0] == AW'(MAX_GRANULES - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req_valid && req_ready) begin
            type_r   <= req_type;
            count_r  <= req_count;
            a8       <= alignment[12:3];
            addr_r   <= block_address;
            res_addr <= '0;
            if (too_small) begin
              res_status <= ST_TOO_SMALL;
              state      <= S_DONE;
            end else if (req_type == REQ_ALLOC) begin
              if (bad_align) begin
                res_status <= ST_BAD_ALIGN;
                state      <= S_DONE;
              end else begin
                rove     <= rove_eff;
                mod_x    <= XW'(ds8) + XW'(rove_eff);
                mod_go   <= 1'b1;
                phase_ff <= 1'b0;
                state    <= S_DIV;
              end
            end else begin
              state <= S_FCHK;
            end
          end
        end
        S_DIV: begin
          if (mod_done) begin
            start <= (phase_ff ? '0 : LW'(rove)) + LW'(adj);
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (fit_over) begin
            if (!phase_ff) begin
              phase_ff <= 1'b1;
              mod_x    <= XW'(ds8);
              mod_go   <= 1'b1;
              state    <= S_DIV;
            end else begin
              res_status <= ST_NO_SPACE;
              state      <= S_DONE;
            end
          end else begin
            idx     <= start;
            end_idx <= fit_sum[LW-1:0];
            pend    <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Reads are issued one per cycle; data of the last issue is checked here.
          if (pend && ram_rdata) begin
            if (!phase_ff) begin
              phase_ff <= 1'b1;
              mod_x    <= XW'(ds8);
              mod_go   <= 1'b1;
              state    <= S_DIV;
            end else begin
              start <= start + LW'(a8);
              state <= S_CHK;
            end
          end else if (idx == end_idx) begin
            idx   <= start;
            state <= S_MARK;
          end else begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end
        end
        S_MARK: begin
          if (idx == end_idx) begin
            if (type_r == REQ_ALLOC) begin
              rove       <= CW'(LW'(rove) + LW'(count_r));
              res_status <= ST_OK;
              res_addr   <= {gsum[28:0], 3'b000};
              state      <= S_DONE;
            end else begin
              rove  <= CW'(start);
              state <= S_BACKRD;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FCHK: begin
          if ((addr_r == 32'd0) || f_below || f_over) begin
            res_status <= ST_FREE_IGNORED;
            state      <= S_DONE;
          end else begin
            start   <= LW'(fdiff[32:3]);
            idx     <= LW'(fdiff[32:3]);
            end_idx <= LW'(fsum);
            state   <= S_MARK;
          end
        end
        S_BACKRD: begin
          // Walk the roving position back over free granules.
          if (rove == '0) begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end else begin
            state <= S_BACKCK;
          end
        end
        S_BACKCK: begin
          if (!ram_rdata) begin
            rove  <= rove_m1;
            state <= S_BACKRD;
          end else begin
            res_status <= ST_OK;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            status          <= res_status;
            granted_address <= res_addr;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
          idx   <= '0;
        end
      endcase

      // Register writes restart the clearing pass.
      if (cfg_valid && cfg_ready && cfg_hit) begin
        if (cfg_index == CFG_REGION_BASE) begin
          region_base <= cfg_data;
        end else begin
          region_size <= cfg_data[12:0];
        end
        state <= S_CLEAR;
        idx   <= '0;
        rove  <= '0;
      end
    end
  end

  // Checks on the sequencer.
  `GBA_ASSERT_IMP(a_we_state, clk, rst, ram_we, (state == S_CLEAR || state == S_MARK))
  `GBA_ASSERT_IMP(a_scan_bound, clk, rst, (state == S_SCAN), (idx <= end_idx))
  `GBA_ASSERT_NEXT(a_cfg_clear, clk, rst, (cfg_valid && cfg_ready && cfg_hit), (state == S_CLEAR))
  `GBA_ASSERT_NEXT(a_done_rsp, clk, rst, (state == S_DONE && (!rsp_valid || rsp_ready)), rsp_valid)

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the bitmap granule allocator.
`timescale 1ns / 1ps
module tb_top;
  import gba_pkg::*;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int NUM_GRANULES   = 512;

  typedef struct {
    logic        kind;
    logic [15:0] nbytes;
    logic [12:0] align;
    logic [31:0] addr;
    bit          free_live;
  } alloc_req_t;

  typedef struct {
    status_t     st;
    logic [31:0] addr;
  } alloc_rsp_t;

  typedef struct {
    logic [31:0] addr;
    logic [15:0] nbytes;
  } live_blk_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic        req_type = REQ_ALLOC;
  logic [15:0] request_bytes = '0;
  logic [12:0] alignment = '0;
  logic [31:0] block_address = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] granted_address;

  // Shadow copy of the allocator state.
  logic [31:0]     sh_base;
  logic [12:0]     sh_size;
  bit              sh_map[NUM_GRANULES];
  longint unsigned sh_rove;
  longint unsigned sh_data_start;
  longint unsigned sh_granules;
  bit              sh_too_small;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  live_blk_t  live_blocks[$];
  alloc_req_t cur_req;

  int  req_gap = 0;
  int  rsp_stall = 0;
  bit  no_idle = 1'b0;
  int  quiet_cycles = 0;
  int  errors = 0;

  always #6 clk = ~clk;

  bitmap_granule_allocator u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .request_bytes(request_bytes), .alignment(alignment), .block_address(block_address),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
    .granted_address(granted_address)
  );

  function automatic longint unsigned round_up(longint unsigned x, longint unsigned a);
    return ((x + a - 1) / a) * a;
  endfunction

  // Derive the region layout and clear the shadow map.
  function automatic void recompute_layout();
    longint unsigned sz, map_bytes, overhead, net;
    sz = (sh_size > SIZE_CAP) ? SIZE_CAP : sh_size;
    map_bytes = (((sz + 7) / 8) + 7) / 8;
    sh_data_start = round_up(longint'(sh_base) + map_bytes, 8);
    overhead = sh_data_start - longint'(sh_base);
    sh_too_small = (overhead >= sz);
    sh_granules = 0;
    if (!sh_too_small) begin
      net = (sz - overhead + 7) / 8;
      sh_granules = (net > NUM_GRANULES) ? NUM_GRANULES : net;
    end
    foreach (sh_map[i]) sh_map[i] = 1'b0;
    sh_rove = 0;
    live_blocks.delete();
  endfunction

  function automatic bit span_free(longint unsigned first, longint unsigned n);
    if (first + n > sh_granules) return 1'b0;
    for (longint unsigned i = first; i < first + n; i++)
      if (sh_map[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void set_span(longint unsigned first, longint unsigned n, bit v);
    for (longint unsigned i = first; i < first + n && i < NUM_GRANULES; i++)
      sh_map[i] = v;
  endfunction

  // Compute the response for one accepted request and update the shadow state.
  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t      res;
    longint unsigned n, cand, first, stride, a;
    live_blk_t       blk;
    res.st = ST_OK;
    res.addr = '0;
    n = (longint'(r.nbytes) + 7) / 8;
    a = r.align;
    if (sh_too_small) begin
      res.st = ST_TOO_SMALL;
      return res;
    end
    if (r.kind == REQ_ALLOC) begin
      if (a == 0 || (a % 8) != 0) begin
        res.st = ST_BAD_ALIGN;
        return res;
      end
      if (sh_rove >= sh_granules) sh_rove = 0;
      cand = round_up(sh_data_start + 8 * sh_rove, a);
      first = (cand - sh_data_start) / 8;
      if (!span_free(first, n)) begin
        cand = round_up(sh_data_start, a);
        first = (cand - sh_data_start) / 8;
        stride = a / 8;
        while (first + n <= sh_granules && !span_free(first, n)) begin
          cand += a;
          first += stride;
        end
        if (first + n > sh_granules) begin
          res.st = ST_NO_SPACE;
          return res;
        end
      end
      set_span(first, n, 1'b1);
      sh_rove += n;
      res.addr = cand[31:0];
      blk.addr = cand[31:0];
      blk.nbytes = r.nbytes;
      live_blocks.push_back(blk);
      return res;
    end
    if (r.addr == 0 || longint'(r.addr) < sh_data_start) begin
      res.st = ST_FREE_IGNORED;
      return res;
    end
    first = (longint'(r.addr) - sh_data_start) / 8;
    if (first + n > sh_granules) begin
      res.st = ST_FREE_IGNORED;
      return res;
    end
    set_span(first, n, 1'b0);
    sh_rove = first;
    while (sh_rove > 0 && sh_rove <= NUM_GRANULES && !sh_map[sh_rove - 1])
      sh_rove--;
    return res;
  endfunction

  // Request driver: one request in flight on the port, random gaps between them unless no_idle is set.
  always @(posedge clk) begin
    int k;
    if (!rst) begin
      if (req_valid && req_ready) begin
        expected_rsps.push_back(predict_alloc(cur_req));
      end
      if (req_valid && !req_ready) begin
        // Hold the request until it is taken.
      end else if (req_gap > 0) begin
        req_gap <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        if (cur_req.free_live && live_blocks.size() > 0) begin
          k = $urandom_range(0, live_blocks.size() - 1);
          cur_req.addr = live_blocks[k].addr;
          // Sometimes free only part of the block, or from an unaligned address.
          cur_req.nbytes = ($urandom_range(0, 5) == 0) ?
                           16'($urandom_range(0, live_blocks[k].nbytes)) : live_blocks[k].nbytes;
          if ($urandom_range(0, 7) == 0) cur_req.addr = cur_req.addr + $urandom_range(1, 7);
          live_blocks.delete(k);
        end
        req_valid <= 1'b1;
        req_type <= cur_req.kind;
        request_bytes <= cur_req.nbytes;
        alignment <= cur_req.align;
        block_address <= cur_req.addr;
        req_gap <= no_idle ? 0 : $urandom_range(0, 16);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response monitor: compare against the oldest expectation, stall at random unless no_idle is set.
  always @(posedge clk) begin
    alloc_rsp_t e;
    int s;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected response status=%0d addr=%h", $time, status,
                   granted_address);
        end else begin
          e = expected_rsps.pop_front();
          if (status !== e.st) begin
            errors++;
            $display("%0t: status mismatch expected=%0d actual=%0d", $time, e.st, status);
          end
          if (granted_address !== e.addr) begin
            errors++;
            $display("%0t: address mismatch expected=%h actual=%h", $time, e.addr,
                     granted_address);
          end
        end
        s = no_idle ? 0 : $urandom_range(0, 16);
        rsp_stall <= s;
        rsp_ready <= (s == 0);
      end else if (rsp_stall > 0) begin
        rsp_stall <= rsp_stall - 1;
        rsp_ready <= (rsp_stall == 1);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL bitmap_granule_allocator");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_REGION_BASE) sh_base = val;
    else sh_size = val[12:0];
    recompute_layout();
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_req(logic kind, int nb, int al, logic [31:0] ad, bit live);
    alloc_req_t r;
    r.kind = kind;
    r.nbytes = nb[15:0];
    r.align = al[12:0];
    r.addr = ad;
    r.free_live = live;
    pending_reqs.push_back(r);
  endtask

  // Mostly well-formed alloc/free traffic, with some malformed and fully random requests.
  task automatic push_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50)
        push_req(REQ_ALLOC, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 600)
                 : $urandom_range(0, 64),
                 ($urandom_range(0, 9) == 0) ? 8 * $urandom_range(1, 512)
                 : (8 << $urandom_range(0, 5)), '0, 1'b0);
      else if (r < 80)
        push_req(REQ_FREE, $urandom_range(0, 64), $urandom_range(0, 8191), 32'd8, 1'b1);
      else if (r < 88)
        push_req(REQ_FREE, $urandom_range(0, 128), $urandom_range(0, 8191),
                 32'(sh_data_start + 8 * $urandom_range(0, 600) + $urandom_range(0, 7)), 1'b0);
      else
        push_req($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 8191),
                 $urandom, 1'b0);
    end
  endtask

  task automatic run_phase(logic [31:0] base, logic [12:0] size, bit quiet, int n);
    wait_drained();
    no_idle = quiet;
    write_reg(CFG_REGION_SIZE, size);
    write_reg(CFG_REGION_BASE, base);
    push_random(n);
  endtask

  initial begin
    sh_base = '0;
    sh_size = 13'd4096;
    recompute_layout();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed cases on the full default region.
    write_reg(CFG_REGION_BASE, 32'd0);
    write_reg(CFG_REGION_SIZE, 13'd4096);
    push_req(REQ_ALLOC, 0, 8, '0, 1'b0);
    push_req(REQ_ALLOC, 1, 8, '0, 1'b0);
    push_req(REQ_ALLOC, 8, 8, '0, 1'b0);
    push_req(REQ_ALLOC, 24, 64, '0, 1'b0);
    push_req(REQ_ALLOC, 16, 4096, '0, 1'b0);
    push_req(REQ_ALLOC, 8, 8184, '0, 1'b0);
    push_req(REQ_ALLOC, 65535, 8, '0, 1'b0);
    push_req(REQ_ALLOC, 8, 0, '0, 1'b0);
    push_req(REQ_ALLOC, 8, 12, '0, 1'b0);
    push_req(REQ_ALLOC, 8, 8191, '0, 1'b0);
    push_req(REQ_FREE, 8, 0, 32'd0, 1'b0);
    push_req(REQ_FREE, 8, 0, 32'd1, 1'b0);
    push_req(REQ_FREE, 8, 0, 32'hFFFFFFFF, 1'b0);
    push_req(REQ_FREE, 65535, 0, 32'd64, 1'b0);
    push_req(REQ_FREE, 8, 0, 32'd75, 1'b0);
    push_req(REQ_FREE, 24, 0, 32'd8, 1'b1);
    push_req(REQ_ALLOC, 4032, 8, '0, 1'b0);
    push_req(REQ_ALLOC, 8, 8, '0, 1'b0);
    push_req(REQ_FREE, 0, 8191, 32'd64, 1'b0);
    push_req(REQ_FREE, 4032, 0, 32'd64, 1'b0);
    push_req(REQ_ALLOC, 16, 16, '0, 1'b0);

    run_phase(32'd0, 13'd4096, 1'b0, 200);
    run_phase($urandom, 13'($urandom_range(9, 200)), 1'b0, 80);
    run_phase($urandom, 13'd0, 1'b0, 20);
    run_phase(32'hFFFFFF00, 13'd4096, 1'b0, 90);
    run_phase(32'd5, 13'd8191, 1'b1, 120);
    run_phase(32'd0, 13'd9, 1'b0, 30);
    run_phase(32'hFFFFFFFF, 13'd8, 1'b0, 10);

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("PASS bitmap_granule_allocator");
    else $display("FAIL bitmap_granule_allocator");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/gba_pkg.sv
hw/rtl/gba_ram.sv
hw/rtl/gba_mod.sv
hw/rtl/bitmap_granule_allocator.sv
tb/sv/tb_top.sv
